// ===== rtl/gna_pkg.sv =====
// Shared types and constants for the grid neighbour average block.
// Used by the fifo, front, back and top modules under rtl; depends on nothing.
`default_nettype none

package gna_pkg;

  localparam int VAL_W      = 16;
  localparam int CFG_W      = 11;
  localparam int SUM_W      = VAL_W + 2;
  localparam int CNT_W      = 3;
  localparam int DIV3_SHIFT = 19;
  localparam logic [SUM_W-1:0] DIV3_MUL = SUM_W'(((1 << DIV3_SHIFT) + 1) / 3);

  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             emit;
    logic             cap;
    logic             last;
    logic             has_up;
    logic             has_down;
    logic             has_left;
    logic             has_right;
    logic [VAL_W-1:0] data;
    logic [VAL_W-1:0] up;
    logic [VAL_W-1:0] right;
  } gna_item_t;

endpackage

`default_nettype wire

// ===== rtl/gna_ram.sv =====
// Generic simple dual-port RAM: one write port, two registered read ports.
// Read-first: a read of the address being written returns the old data.
`default_nettype none

module gna_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gna_fifo.sv =====
// Short queue of classified work items between front and back end.
// Depends on gna_pkg for the item type and depth.
`default_nettype none

module gna_fifo (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  input  wire gna_pkg::gna_item_t        push_item_i,
  input  wire logic                      pop_i,
  output gna_pkg::gna_item_t             head_o,
  output logic                           avail_o,
  output logic [gna_pkg::FCNT_W-1:0]     count_o
);
  import gna_pkg::*;

  gna_item_t         mem_q [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FCNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + FCNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - FCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign avail_o = (count_q != '0);
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== rtl/gna_front.sv =====
// Front end: geometry registers, frame counters, line ring and item classification.
// Depends on gna_pkg and gna_ram; feeds classified items to gna_fifo.
`default_nettype none

module gna_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [gna_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [gna_pkg::VAL_W-1:0]   s_axis_tdata,
  input  wire logic                        s_axis_tuser,
  input  wire logic [gna_pkg::FCNT_W-1:0]  fifo_count_i,
  output logic                             push_o,
  output gna_pkg::gna_item_t               push_item_o
);
  import gna_pkg::*;

  localparam int GW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int AW  = $clog2(2 * MAX_WIDTH);
  localparam int TW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int CMW = (CFG_W > GW) ? CFG_W : GW;
  localparam int CMH = (CFG_W > HW) ? CFG_W : HW;
  localparam int RST_W = (64 > MAX_WIDTH) ? MAX_WIDTH : 64;
  localparam int RST_H = (64 > MAX_HEIGHT) ? MAX_HEIGHT : 64;

  logic [GW-1:0] weff_q, weff_d;
  logic [HW-1:0] heff_q, heff_d;
  logic [TW-1:0] total_q, total_d;
  logic [TW-1:0] rcv_q, rcv_d;
  logic [TW-1:0] emt_q, emt_d;
  logic [AW-1:0] wslot_q, wslot_d;
  logic [AW-1:0] eslot_q, eslot_d;
  logic [XW-1:0] ex_q, ex_d;
  logic          s1_valid_q, s1_valid_d;
  gna_item_t     s1_q, s1_d;

  logic [CMW-1:0]   cw;
  logic [CMH-1:0]   ch;
  logic [GW-1:0]    wnew, mul_a;
  logic [HW-1:0]    hnew, mul_b;
  logic [GW+HW-1:0] prod;
  logic [AW-1:0]    w2m1, wa, up_slot, rt_slot;
  logic [FCNT_W:0]  occ;
  logic             fire, cmd_flush, cell_ok, cap, emit_cell, flush_ok, emit, last;
  logic             has_up, has_left, has_right, ex_end;

  // geometry clamp and frame size
  always_comb begin
    cw = CMW'(cfg_data_i);
    ch = CMH'(cfg_data_i);
    if (cw == '0) begin
      wnew = GW'(1);
    end else if (cw > CMW'(MAX_WIDTH)) begin
      wnew = GW'(MAX_WIDTH);
    end else begin
      wnew = GW'(cw);
    end
    if (ch == '0) begin
      hnew = HW'(1);
    end else if (ch > CMH'(MAX_HEIGHT)) begin
      hnew = HW'(MAX_HEIGHT);
    end else begin
      hnew = HW'(ch);
    end
    mul_a = (cfg_idx_i == REG_WIDTH)  ? wnew : weff_q;
    mul_b = (cfg_idx_i == REG_HEIGHT) ? hnew : heff_q;
    prod  = (GW+HW)'(mul_a) * (GW+HW)'(mul_b);
  end

  // classification
  always_comb begin
    occ       = {1'b0, fifo_count_i} + (FCNT_W+1)'(s1_valid_q);
    s_axis_tready = (occ < (FCNT_W+1)'(FIFO_DEPTH));
    fire      = s_axis_tvalid && s_axis_tready;
    cmd_flush = s_axis_tuser;
    cell_ok   = !cmd_flush && (rcv_q < total_q);
    cap       = cell_ok && (rcv_q == '0);
    emit_cell = cell_ok && (rcv_q >= TW'(weff_q));
    flush_ok  = cmd_flush && (rcv_q >= total_q) && (emt_q < total_q);
    emit      = emit_cell || flush_ok;
    last      = flush_ok && (emt_q == total_q - TW'(1));
    has_up    = (emt_q >= TW'(weff_q));
    has_left  = (ex_q != '0);
    ex_end    = ((GW'(ex_q) + GW'(1)) == weff_q);
    has_right = !ex_end;
    w2m1      = AW'({weff_q, 1'b0}) - AW'(1);
    wa        = AW'(weff_q);
    up_slot   = (eslot_q >= wa) ? eslot_q - wa : eslot_q + wa;
    rt_slot   = (eslot_q == w2m1) ? '0 : eslot_q + AW'(1);
  end

  // next state
  always_comb begin
    weff_d     = weff_q;
    heff_d     = heff_q;
    total_d    = total_q;
    rcv_d      = rcv_q;
    emt_d      = emt_q;
    wslot_d    = wslot_q;
    eslot_d    = eslot_q;
    ex_d       = ex_q;
    s1_valid_d = 1'b0;
    s1_d           = s1_q;
    s1_d.emit      = emit;
    s1_d.cap       = cap;
    s1_d.last      = last;
    s1_d.has_up    = has_up;
    s1_d.has_down  = !cmd_flush;
    s1_d.has_left  = has_left;
    s1_d.has_right = has_right;
    s1_d.data      = s_axis_tdata;
    if (cfg_we_i) begin
      if (cfg_idx_i == REG_WIDTH) begin
        weff_d = wnew;
      end else begin
        heff_d = hnew;
      end
      total_d = TW'(prod);
      rcv_d   = '0;
      emt_d   = '0;
      wslot_d = '0;
      eslot_d = '0;
      ex_d    = '0;
    end else if (fire) begin
      s1_valid_d = emit || cap;
      if (cell_ok) begin
        rcv_d   = rcv_q + TW'(1);
        wslot_d = (wslot_q == w2m1) ? '0 : wslot_q + AW'(1);
      end
      if (emit) begin
        emt_d   = emt_q + TW'(1);
        eslot_d = rt_slot;
        ex_d    = ex_end ? '0 : ex_q + XW'(1);
      end
      if (last) begin
        rcv_d   = '0;
        emt_d   = '0;
        wslot_d = '0;
        eslot_d = '0;
        ex_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weff_q     <= GW'(RST_W);
      heff_q     <= HW'(RST_H);
      total_q    <= TW'(RST_W * RST_H);
      rcv_q      <= '0;
      emt_q      <= '0;
      wslot_q    <= '0;
      eslot_q    <= '0;
      ex_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      weff_q     <= weff_d;
      heff_q     <= heff_d;
      total_q    <= total_d;
      rcv_q      <= rcv_d;
      emt_q      <= emt_d;
      wslot_q    <= wslot_d;
      eslot_q    <= eslot_d;
      ex_q       <= ex_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  logic [VAL_W-1:0] up_rd, rt_rd;

  gna_ram #(
    .WIDTH (VAL_W),
    .DEPTH (2 * MAX_WIDTH)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (fire && cell_ok && !cfg_we_i),
    .waddr_i   (wslot_q),
    .wdata_i   (s_axis_tdata),
    .raddr_a_i (up_slot),
    .raddr_b_i (rt_slot),
    .rdata_a_o (up_rd),
    .rdata_b_o (rt_rd)
  );

  always_comb begin
    push_item_o       = s1_q;
    push_item_o.up    = up_rd;
    push_item_o.right = rt_rd;
  end

  assign push_o = s1_valid_q;

endmodule

`default_nettype wire

// ===== rtl/gna_back.sv =====
// Back end: neighbour window, sum, divide by neighbour count, output register.
// Depends on gna_pkg; pops items from gna_fifo.
`default_nettype none

module gna_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire gna_pkg::gna_item_t         head_i,
  input  wire logic                       avail_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [gna_pkg::VAL_W-1:0]       m_axis_tdata,
  output logic                            m_axis_tlast
);
  import gna_pkg::*;

  logic             b1_valid_q, b1_valid_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             b1_last_q, b1_last_d;
  logic [VAL_W-1:0] lft_q, lft_d;
  logic [VAL_W-1:0] mid_q, mid_d;
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_data_q, out_data_d;
  logic             out_last_q, out_last_d;

  logic               out_en, pop;
  logic [2*SUM_W-1:0] prod;
  logic [VAL_W-1:0]   quot;

  always_comb begin
    out_en = !out_valid_q || m_axis_tready;
    pop    = avail_i && (!b1_valid_q || out_en);

    b1_valid_d = out_en ? 1'b0 : b1_valid_q;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    b1_last_d  = b1_last_q;
    lft_d      = lft_q;
    mid_d      = mid_q;
    if (pop && head_i.cap) begin
      mid_d = head_i.data;
    end
    if (pop && head_i.emit) begin
      b1_valid_d = 1'b1;
      sum_d = (head_i.has_up    ? SUM_W'(head_i.up)    : '0)
            + (head_i.has_down  ? SUM_W'(head_i.data)  : '0)
            + (head_i.has_left  ? SUM_W'(lft_q)        : '0)
            + (head_i.has_right ? SUM_W'(head_i.right) : '0);
      cnt_d = CNT_W'(head_i.has_up) + CNT_W'(head_i.has_down)
            + CNT_W'(head_i.has_left) + CNT_W'(head_i.has_right);
      b1_last_d = head_i.last;
      lft_d     = mid_q;
      mid_d     = head_i.right;
    end
  end

  // truncating divide by the neighbour count
  always_comb begin
    prod = (2*SUM_W)'(sum_q) * (2*SUM_W)'(DIV3_MUL);
    case (cnt_q)
      3'd4:    quot = sum_q[2 +: VAL_W];
      3'd3:    quot = prod[DIV3_SHIFT +: VAL_W];
      3'd2:    quot = sum_q[1 +: VAL_W];
      3'd1:    quot = sum_q[VAL_W-1:0];
      default: quot = '0;
    endcase
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (out_en) begin
      out_valid_d = b1_valid_q;
      out_data_d  = quot;
      out_last_d  = b1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b1_valid_q  <= b1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    cnt_q      <= cnt_d;
    b1_last_q  <= b1_last_d;
    lft_q      <= lft_d;
    mid_q      <= mid_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign pop_o         = pop;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/grid_neighbour_average.sv =====
// Four-neighbour average over a raster-order grid stream, one result per cell.
// Throughput: one item per cycle unless stalled; ring RAM: two read ports, one write port.
// Path: front stage register, queue, sum register, output register, held by back-pressure.
// The front stalls when queued items plus the one entering the queue reach four.
// Reset: asynchronous, clears counters, sets width, height to min(64, MAX_*); no clearing pass.
`default_nettype none

module grid_neighbour_average #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [gna_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [gna_pkg::VAL_W-1:0] s_axis_tdata,  // [15:0] cell_value
  input  wire logic                      s_axis_tuser,  // [0] command
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [gna_pkg::VAL_W-1:0]      m_axis_tdata,  // [15:0] avg_value
  output logic                           m_axis_tlast
);
  import gna_pkg::*;

  logic              push, pop, avail;
  gna_item_t         push_item, head;
  logic [FCNT_W-1:0] fifo_count;

  gna_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .fifo_count_i  (fifo_count),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  gna_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .avail_o     (avail),
    .count_o     (fifo_count)
  );

  gna_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .avail_i       (avail),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
